// File: sv/tmcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants and the command word passed from the front end to the
// back end of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  // Widest row and column indexes over the supported screen sizes
  localparam int ROW_BITS_MAX = 7;
  localparam int COL_BITS_MAX = 8;

  // Input word kinds
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Back-end operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Attribute after reset: grey on black
  localparam logic [7:0] RESET_ATTR = 8'h07;

  // One command for the back end, with the result it must report
  typedef struct packed {
    logic [1:0]              op;
    logic                    scroll;     // blank blank_row after the op
    logic [ROW_BITS_MAX-1:0] row;        // physical row for write or read
    logic [COL_BITS_MAX-1:0] col;
    logic [ROW_BITS_MAX-1:0] blank_row;  // physical row that becomes the bottom
    logic [7:0]              ch;
    logic [7:0]              attr;
    logic [4:0]              res_row;
    logic [6:0]              res_col;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/tmcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/tmcw_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tmcw_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tmcw_pkg::cmd_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output tmcw_pkg::cmd_t       pop_data,
  output logic                 empty
);
  import tmcw_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CNTW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/tmcw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts input words, owns the cursor, the scroll offset and the attribute,
// and turns each word into one back-end command carrying its result.
// ----------------------------------------------------------------------------
module tmcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [23:0]     s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic [1:0]      s_tuser,   // mode[1:0]
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            hold,
  output logic                 push,
  output tmcw_pkg::cmd_t       push_data,
  input  wire logic            full
);
  import tmcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [RW-1:0] cur_y;
  logic [CW-1:0] cur_x;
  logic [RW-1:0] cur_prow;   // physical row of the cursor
  logic [RW-1:0] top;        // physical row shown at the top
  logic [7:0]    attr;

  logic [RW-1:0] y_next;
  logic [CW-1:0] x_next;
  logic [RW-1:0] prow_next;
  logic [RW-1:0] top_next;
  logic          accept;
  logic          new_line;
  logic          rd_ok;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_prow;
  logic [RW:0]   chk_sum;
  logic [RW-1:0] chk_prow;
  logic [1:0]    mode;
  logic [7:0]    ch;
  logic [4:0]    rd_row;
  logic [6:0]    rd_col;
  cmd_t          cmd;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (32'(r) == ROWS - 1) ? '0 : r + RW'(1);
  endfunction

  assign mode   = s_tuser;
  assign ch     = s_tdata[7:0];
  assign rd_row = s_tdata[12:8];
  assign rd_col = s_tdata[19:13];

  assign s_tready  = !full && !hold;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept;
  assign push_data = cmd;
  assign cfg_ready = 1'b1;

  // Logical read row to physical row
  always_comb begin
    rd_ok   = (32'(rd_row) < ROWS) && (32'(rd_col) < COLUMNS);
    rd_sum  = (RW + 1)'(RW'(32'(rd_row))) + (RW + 1)'(top);
    rd_prow = (32'(rd_sum) >= ROWS) ? RW'(rd_sum - (RW + 1)'(ROWS)) : RW'(rd_sum);
  end

  // Decode and cursor update
  always_comb begin
    y_next    = cur_y;
    x_next    = cur_x;
    prow_next = cur_prow;
    top_next  = top;
    new_line  = 1'b0;
    cmd       = '0;
    cmd.ch    = ch;
    cmd.attr  = attr;
    unique case (mode)
      MODE_PUT: begin
        if (ch == CH_NEWLINE) begin
          new_line = 1'b1;
        end else if (ch == CH_RETURN) begin
          x_next = '0;
        end else begin
          cmd.op  = OP_WRITE;
          cmd.row = ROW_BITS_MAX'(cur_prow);
          cmd.col = COL_BITS_MAX'(cur_x);
          if (32'(cur_x) == COLUMNS - 1) begin
            new_line = 1'b1;
          end else begin
            x_next = cur_x + CW'(1);
          end
        end
        if (new_line) begin
          x_next = '0;
          if (32'(cur_y) == ROWS - 1) begin
            // old top row is blanked and becomes the bottom row
            cmd.scroll    = 1'b1;
            cmd.blank_row = ROW_BITS_MAX'(top);
            prow_next     = top;
            top_next      = row_inc(top);
          end else begin
            y_next    = cur_y + RW'(1);
            prow_next = row_inc(cur_prow);
          end
        end
      end
      MODE_CLEAR: begin
        cmd.op    = OP_CLEAR;
        y_next    = '0;
        x_next    = '0;
        prow_next = '0;
        top_next  = '0;
      end
      MODE_READ: begin
        if (rd_ok) begin
          cmd.op  = OP_READ;
          cmd.row = ROW_BITS_MAX'(rd_prow);
          cmd.col = COL_BITS_MAX'(rd_col);
        end
      end
      default: begin
      end
    endcase
    cmd.res_row = 5'(32'(y_next));
    cmd.res_col = 7'(32'(x_next));
  end

  // Cursor and scroll state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_y    <= '0;
      cur_x    <= '0;
      cur_prow <= '0;
      top      <= '0;
    end else if (accept) begin
      cur_y    <= y_next;
      cur_x    <= x_next;
      cur_prow <= prow_next;
      top      <= top_next;
    end
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_valid) begin
      attr <= cfg_data;
    end
  end

  // Expected physical cursor row, for checking
  always_comb begin
    chk_sum  = (RW + 1)'(cur_y) + (RW + 1)'(top);
    chk_prow = (32'(chk_sum) >= ROWS) ? RW'(chk_sum - (RW + 1)'(ROWS)) : RW'(chk_sum);
  end

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_y) < ROWS) && (32'(cur_x) < COLUMNS))
    else $error("cursor outside the screen");

  a_prow_tracks_offset: assert property (@(posedge clk) disable iff (rst)
    cur_prow == chk_prow)
    else $error("physical cursor row out of step with scroll offset");

endmodule
`default_nettype wire

// File: sv/tmcw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_back
// Executes commands on the cell store: single-cell writes and reads, row
// blanking on scroll, full-screen sweeps for clear and reset; returns one
// result word per command through a result stage and an output register.
// ----------------------------------------------------------------------------
module tmcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tmcw_pkg::cmd_t  cmd,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 hold,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata    // cell_data[15:0], cursor_row[20:16],
                                          // cursor_col[27:21], scrolled[28]
);
  import tmcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic          sweeping;
  logic          init_run;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] sweep_last;
  logic [15:0]   sweep_word;

  logic          pend_valid;
  logic          pend_rd;
  logic [4:0]    pend_row;
  logic [6:0]    pend_col;
  logic          pend_scr;
  logic          pend_move;

  logic          out_valid;
  logic [15:0]   out_data;
  logic [4:0]    out_row;
  logic [6:0]    out_col;
  logic          out_scr;

  logic [AW-1:0] cmd_addr;
  logic [AW-1:0] blank_base;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [15:0]   ram_rdata;

  assign hold      = init_run;
  assign pend_move = pend_valid && (!out_valid || m_tready);
  assign pop       = !empty && !sweeping && (!pend_valid || pend_move);

  // Cell addresses
  assign cmd_addr   = AW'(cmd.row) * AW'(COLUMNS) + AW'(cmd.col);
  assign blank_base = AW'(cmd.blank_row) * AW'(COLUMNS);

  // Store ports: a sweep owns the write port
  assign ram_we    = sweeping || (pop && (cmd.op == OP_WRITE));
  assign ram_waddr = sweeping ? sweep_addr : cmd_addr;
  assign ram_wdata = sweeping ? sweep_word : {cmd.attr, cmd.ch};
  assign ram_re    = pop && (cmd.op == OP_READ);

  tmcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cmd_addr),
    .rdata (ram_rdata)
  );

  // Fill sweeps: whole store after reset and on clear, one row on scroll
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      init_run   <= 1'b1;
      sweep_addr <= '0;
      sweep_last <= AW'(CELLS - 1);
      sweep_word <= {RESET_ATTR, CH_SPACE};
    end else if (sweeping) begin
      if (sweep_addr == sweep_last) begin
        sweeping <= 1'b0;
        init_run <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + AW'(1);
      end
    end else if (pop && (cmd.op == OP_CLEAR)) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      sweep_last <= AW'(CELLS - 1);
      sweep_word <= {cmd.attr, CH_SPACE};
    end else if (pop && cmd.scroll) begin
      sweeping   <= 1'b1;
      sweep_addr <= blank_base;
      sweep_last <= blank_base + AW'(COLUMNS - 1);
      sweep_word <= {cmd.attr, CH_SPACE};
    end
  end

  // Result stage, waits for the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pop) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_rd  <= (cmd.op == OP_READ);
      pend_row <= cmd.res_row;
      pend_col <= cmd.res_col;
      pend_scr <= cmd.scroll;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= pend_rd ? ram_rdata : 16'd0;
      out_row  <= pend_row;
      out_col  <= pend_col;
      out_scr  <= pend_scr;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_scr, out_col, out_row, out_data};

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> (sweep_addr <= sweep_last))
    else $error("fill sweep ran past its end");

  a_init_is_sweep: assert property (@(posedge clk) disable iff (rst)
    init_run |-> sweeping)
    else $error("reset fill flagged without a sweep");

  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_move) |=> (pend_valid && $stable(pend_row) && $stable(pend_rd)))
    else $error("stalled result lost or changed");

endmodule
`default_nettype wire

// File: sv/text_mode_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text-mode terminal: a ROWS x COLUMNS cell store with cursor and scrolling.
// ----------------------------------------------------------------------------
// Input words arrive on s_*: s_tuser holds the mode (0 put character,
// 1 clear screen, 2 read one cell), s_tdata the character and the read
// position. Each word gives exactly one result word on m_*, in order, with
// the read cell, the cursor after the word and a scroll flag.
// The user must write the attribute byte on cfg_* (always ready) only while
// idle; the block does not enforce this. Put and read words run at one per
// cycle while m_tready stays high and no sweep runs, limited by the single
// write and read port of the store. A word that scrolls holds the back end
// while it blanks one row (rows rotate through a top-row offset, nothing is
// copied); a clear holds it while it fills the whole store. The 4-entry
// command queue keeps taking input meanwhile until full. After reset the
// ROWS*COLUMNS cells (2000 at 80x25) are filled with grey spaces; s_tready
// stays low until that pass ends. When the receiver stalls, the result sits
// in the output register, one more in the result stage, then the queue
// fills and s_tready drops.
// ----------------------------------------------------------------------------
module text_mode_console_writer #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // cell_data[15:0], cursor_row[20:16],
                                      // cursor_col[27:21], scrolled[28]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import tmcw_pkg::*;

  cmd_t push_data;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;
  logic hold;

  tmcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .hold      (hold),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tmcw_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head),
    .empty    (empty),
    .pop      (pop),
    .hold     (hold),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
